// ===== hw/rtl/lldf_pkg.sv =====
// Package for the light level debounce filter: sizes, divide constants, codes and types.
`default_nettype none
package lldf_pkg;

    // Ring geometry (legal range 3 to 32 entries).
    localparam int RING_DEPTH = 8;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 3;
    localparam int HOLD_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // The ring sum and the trimmed sum both fit in this width.
    localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);

    // Floor division by RING_DEPTH-2 is a multiply by a rounded-up reciprocal.
    // With the shift at SUM_W plus the ceiling log2 of the divisor the quotient is exact
    // for every trimmed sum.
    localparam int DIVISOR  = RING_DEPTH - 2;
    localparam int DIV_SH   = SUM_W + $clog2(DIVISOR);
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SH) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
    localparam int RECIP_W  = DIV_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W   = SUM_W + RECIP_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_HOLD_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_HOLD_COUNT  = 3'd5;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0] THRESHOLD_LEVEL0_RST = 16'd15;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_LEVEL1_RST = 16'd163;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_LEVEL2_RST = 16'd1650;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_LEVEL3_RST = 16'd15700;
    localparam logic [HOLD_W-1:0]   RISE_HOLD_COUNT_RST  = 5'd5;
    localparam logic [HOLD_W-1:0]   FALL_HOLD_COUNT_RST  = 5'd20;

    // Brightness levels.
    localparam logic [LEVEL_W-1:0] LEVEL_0 = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_TRIM = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DEB  = 5'b10000
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/lldf_in_if.sv =====
// Input channel of the light level debounce filter: one ADC sample per beat.
`default_nettype none
interface lldf_in_if
    import lldf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lldf_out_if.sv =====
// Output channel of the light level debounce filter: one level report per beat.
`default_nettype none
interface lldf_out_if
    import lldf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] reported_value;
    logic [LEVEL_W-1:0]  reported_level;

    modport source (output valid, output reported_value, output reported_level, input ready);
    modport sink   (input valid, input reported_value, input reported_level, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/light_level_debounce_filter.sv =====
// Light level debounce filter: sample ring, trimmed mean, level classify and debounce.
//
// Usage: every beat on i_in carries one 16-bit light ADC sample and a restart flag.
// The sample is written into a ring of RING_DEPTH entries (restart fills all of
// them and clears the debounce). A single shared adder/comparator then walks the
// ring one entry per cycle, collecting the sum, the largest and the smallest
// entry. The trimmed sum is divided by RING_DEPTH-2 with one reciprocal multiply,
// classified against four thresholds, and the debounce decides whether a report
// goes out on o_out as one beat of value and level.
// Sequence: after acceptance the sequencer scans the ring, then passes through
// the trim, multiply and debounce states; the report register is loaded in debounce.
// i_in.ready is high only while the sequencer is idle, so a new sample is not
// accepted until the previous one has left the debounce state. Most samples
// produce no report.
// The report register lets the next sample be accepted while a report waits;
// if o_out stalls, a following item holds in its debounce step until the
// report register is free.
// Reset (synchronous, active low) clears the ring, the debounce state and the
// report register, and restores the register defaults. Configuration writes on
// i_cfg_* take effect at once and are meant for idle periods.
`default_nettype none
module light_level_debounce_filter
    import lldf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lldf_in_if.sink                    i_in,
    lldf_out_if.source                 o_out
);

    // Configuration registers.
    logic [SAMPLE_W-1:0] r_thr0, r_thr1, r_thr2, r_thr3;
    logic [HOLD_W-1:0]   r_rise_hold, r_fall_hold;

    // Ring and its write pointer.
    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [RING_AW-1:0]  r_ring_pos;

    // Sequencer and scan datapath.
    t_state              r_state;
    logic [RING_AW-1:0]  r_idx;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_max, r_min;
    logic [PROD_W-1:0]   r_prod;

    // Debounce state.
    logic [LEVEL_W-1:0]  r_cand_level;
    logic [HOLD_W-1:0]   r_hold_cnt;
    logic [LEVEL_W-1:0]  r_acc_level;
    logic                r_first_pend;

    // Report register.
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_value;
    logic [LEVEL_W-1:0]  r_out_level;

    logic                in_beat;
    logic                out_free;
    logic                deb_go;
    logic [SAMPLE_W-1:0] scan_elem;
    logic [SAMPLE_W-1:0] value;
    logic [LEVEL_W-1:0]  level;
    logic                rising;
    logic [HOLD_W-1:0]   hold_target;
    logic                level_same;
    logic                report;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign deb_go     = (r_state == ST_DEB) && out_free;

    assign o_out.valid          = r_out_valid;
    assign o_out.reported_value = r_out_value;
    assign o_out.reported_level = r_out_level;

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr0      <= THRESHOLD_LEVEL0_RST;
            r_thr1      <= THRESHOLD_LEVEL1_RST;
            r_thr2      <= THRESHOLD_LEVEL2_RST;
            r_thr3      <= THRESHOLD_LEVEL3_RST;
            r_rise_hold <= RISE_HOLD_COUNT_RST;
            r_fall_hold <= FALL_HOLD_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD_LEVEL0: r_thr0      <= i_cfg_data;
                CFG_THRESHOLD_LEVEL1: r_thr1      <= i_cfg_data;
                CFG_THRESHOLD_LEVEL2: r_thr2      <= i_cfg_data;
                CFG_THRESHOLD_LEVEL3: r_thr3      <= i_cfg_data;
                CFG_RISE_HOLD_COUNT:  r_rise_hold <= i_cfg_data[HOLD_W-1:0];
                CFG_FALL_HOLD_COUNT:  r_fall_hold <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Ring write: restart fills every entry, otherwise one entry at the pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_ring_pos <= '0;
        end else if (in_beat) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                if (i_in.restart || (r_ring_pos == RING_AW'(i))) begin
                    r_ring[i] <= i_in.sample;
                end
            end
            if (r_ring_pos == RING_AW'(RING_DEPTH - 1)) begin
                r_ring_pos <= '0;
            end else begin
                r_ring_pos <= r_ring_pos + 1'b1;
            end
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (in_beat) r_state <= ST_SCAN;
                ST_SCAN: if (r_idx == RING_AW'(RING_DEPTH - 1)) r_state <= ST_TRIM;
                ST_TRIM: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_DEB;
                ST_DEB:  if (out_free) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Shared accumulate and compare unit: one ring entry per scan cycle.
    assign scan_elem = r_ring[r_idx];

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_idx <= '0;
            r_sum <= '0;
            r_max <= '0;
            r_min <= '1;
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + 1'b1;
            r_sum <= r_sum + SUM_W'(scan_elem);
            if (scan_elem > r_max) r_max <= scan_elem;
            if (scan_elem < r_min) r_min <= scan_elem;
        end else if (r_state == ST_TRIM) begin
            r_sum <= r_sum - SUM_W'(r_max) - SUM_W'(r_min);
        end
    end

    // Floor divide by RING_DEPTH-2 through the reciprocal multiply.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP);
        end
    end

    assign value = r_prod[DIV_SH +: SAMPLE_W];

    // Level classify; the first threshold that holds wins.
    always_comb begin
        priority if (value <= r_thr0) level = LEVEL_0;
        else if (value <= r_thr1)     level = LEVEL_1;
        else if (value <= r_thr2)     level = LEVEL_2;
        else if (value <= r_thr3)     level = LEVEL_3;
        else                          level = LEVEL_4;
    end

    assign level_same  = (r_cand_level == level);
    assign rising      = (r_acc_level <= level) || r_first_pend;
    assign hold_target = rising ? r_rise_hold : r_fall_hold;
    assign report      = level_same && (r_hold_cnt == hold_target);

    // Debounce; a restart beat clears candidate and count before this item's decision.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_level <= LEVEL_0;
            r_hold_cnt   <= '0;
            r_acc_level  <= LEVEL_0;
            r_first_pend <= 1'b0;
        end else if (in_beat && i_in.restart) begin
            r_cand_level <= LEVEL_0;
            r_hold_cnt   <= '0;
            r_first_pend <= 1'b1;
        end else if (deb_go) begin
            if (!level_same) begin
                r_cand_level <= level;
                r_hold_cnt   <= '0;
            end else if (!report) begin
                r_hold_cnt <= r_hold_cnt + 1'b1;
            end else begin
                r_hold_cnt  <= '0;
                r_acc_level <= level;
                if (rising) r_first_pend <= 1'b0;
            end
        end
    end

    // Report register: filled by a debounce report, emptied by the output beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (deb_go && report) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (deb_go && report) begin
            r_out_value <= value;
            r_out_level <= level;
        end
    end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the light level debounce filter with its own level predictor.
module testbench;
    import lldf_pkg::*;

    localparam int RANDOM_ITEMS  = 1950;
    localparam int SETTLE_CYCLES = 3 * (RING_DEPTH + 4);
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } adc_beat_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [LEVEL_W-1:0]  level;
    } level_report_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    lldf_in_if  in_ch ();
    lldf_out_if out_ch ();

    light_level_debounce_filter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Stimulus and expectation stores.
    adc_beat_t     sample_backlog [$];
    level_report_t reports_due [$];

    // Predictor state and its copy of the registers.
    logic [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
    int unsigned         ring_wr;
    logic [LEVEL_W-1:0]  cand_level;
    logic [LEVEL_W-1:0]  held_level;
    logic [HOLD_W-1:0]   hold_cnt;
    logic                first_pending;
    logic [SAMPLE_W-1:0] th_lvl [4];
    logic [HOLD_W-1:0]   rise_hold;
    logic [HOLD_W-1:0]   fall_hold;

    // Bookkeeping shared between the processes.
    bit pace_mode = 1'b1;
    int beats_accepted = 0;
    int reports_predicted = 0;
    int reports_received = 0;
    int mismatches = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit drain_hold = 1'b0;
    int cycle_count = 0;
    int phase_count = 0;
    int random_items = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // First threshold that the value does not exceed decides the level.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [SAMPLE_W-1:0] v);
        if (v <= th_lvl[0]) return LEVEL_0;
        if (v <= th_lvl[1]) return LEVEL_1;
        if (v <= th_lvl[2]) return LEVEL_2;
        if (v <= th_lvl[3]) return LEVEL_3;
        return LEVEL_4;
    endfunction

    // Stores one sample, forms the trimmed mean and runs the debounce.
    // Returns 1 when the sample leads to a report.
    function automatic bit filter_sample(input logic [SAMPLE_W-1:0] smp, input logic restart,
                                         output level_report_t rep);
        int unsigned         sum;
        int unsigned         hi;
        int unsigned         lo;
        logic [SAMPLE_W-1:0] mean;
        logic [LEVEL_W-1:0]  lvl;
        bit                  rising;
        rep = '0;
        if (restart) begin
            for (int k = 0; k < RING_DEPTH; k++) ring_copy[k] = smp;
            hold_cnt = '0;
            cand_level = LEVEL_0;
            first_pending = 1'b1;
        end else begin
            ring_copy[ring_wr] = smp;
        end
        ring_wr = (ring_wr + 1 >= RING_DEPTH) ? 0 : ring_wr + 1;

        sum = 0;
        hi = 32'(ring_copy[0]);
        lo = 32'(ring_copy[0]);
        for (int k = 0; k < RING_DEPTH; k++) begin
            sum += 32'(ring_copy[k]);
            if (ring_copy[k] > hi) hi = 32'(ring_copy[k]);
            if (ring_copy[k] < lo) lo = 32'(ring_copy[k]);
        end
        mean = SAMPLE_W'((sum - hi - lo) / (RING_DEPTH - 2));
        lvl = level_of(mean);

        // A new level restarts the count; a steady one counts up to its hold.
        if (lvl != cand_level) begin
            cand_level = lvl;
            hold_cnt = '0;
            return 1'b0;
        end
        rising = (held_level <= lvl) || first_pending;
        if (hold_cnt != (rising ? rise_hold : fall_hold)) begin
            hold_cnt = hold_cnt + 1'b1;
            return 1'b0;
        end
        hold_cnt = '0;
        held_level = lvl;
        if (rising) first_pending = 1'b0;
        rep.value = mean;
        rep.level = lvl;
        return 1'b1;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_beat(input int value, input bit restart);
        adc_beat_t beat;
        if (value < 0) value = 0;
        if (value > 65535) value = 65535;
        beat.sample = SAMPLE_W'(value);
        beat.restart = restart;
        sample_backlog.push_back(beat);
    endtask

    // A run of samples around one light level, with an occasional spike.
    task automatic add_run(input int count, input int center, input int spread,
                           input bit restart_first);
        int v;
        for (int n = 0; n < count; n++) begin
            v = center + int'($urandom_range(0, 2 * spread)) - spread;
            if ($urandom_range(0, 14) == 0) v = $urandom_range(0, 65535);
            push_beat(v, restart_first && (n == 0));
        end
    endtask

    // Steady runs with random content, mixed with lone noise samples.
    task automatic fill_random(input int total);
        int left;
        int len;
        int center;
        int spread;
        int pick;
        left = total;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                push_beat($urandom_range(0, 65535), $urandom_range(0, 3) == 0);
                left--;
            end else begin
                if (pick < 55) center = $urandom_range(0, 65535) >> $urandom_range(0, 15);
                else if (pick < 80)
                    center = int'(th_lvl[$urandom_range(0, 3)]) + int'($urandom_range(0, 8)) - 4;
                else center = $urandom_range(0, 65535);
                if (center < 0) center = 0;
                spread = (center >> $urandom_range(3, 8)) + int'($urandom_range(0, 2));
                len = $urandom_range(1, 45);
                if (len > left) len = left;
                add_run(len, center, spread, $urandom_range(0, 6) == 0);
                left -= len;
            end
        end
        random_items += total;
    endtask

    // Writes all six registers back to back; the block must be idle.
    task automatic set_config(input logic [SAMPLE_W-1:0] t0, input logic [SAMPLE_W-1:0] t1,
                              input logic [SAMPLE_W-1:0] t2, input logic [SAMPLE_W-1:0] t3,
                              input logic [HOLD_W-1:0] rise, input logic [HOLD_W-1:0] fall);
        logic [CFG_IDX_W-1:0]  reg_idx [6];
        logic [CFG_DATA_W-1:0] reg_val [6];
        reg_idx = '{CFG_THRESHOLD_LEVEL0, CFG_THRESHOLD_LEVEL1, CFG_THRESHOLD_LEVEL2,
                    CFG_THRESHOLD_LEVEL3, CFG_RISE_HOLD_COUNT, CFG_FALL_HOLD_COUNT};
        reg_val = '{t0, t1, t2, t3, CFG_DATA_W'(rise), CFG_DATA_W'(fall)};
        for (int r = 0; r < 6; r++) begin
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= reg_idx[r];
            i_cfg_data  <= reg_val[r];
        end
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        th_lvl[0] = t0;
        th_lvl[1] = t1;
        th_lvl[2] = t2;
        th_lvl[3] = t3;
        rise_hold = rise;
        fall_hold = fall;
        phase_count++;
        @(negedge i_clk);
    endtask

    // Waits until every sample is in and every report is out, then lets the
    // last sample finish even if it makes no report.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_backlog.size() != 0 || in_ch.valid || reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Input driver: presents backlog samples and predicts each accepted one.
    always @(posedge i_clk) begin : sample_driver
        level_report_t rep;
        adc_beat_t     beat;
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.sample  <= '0;
            in_ch.restart <= 1'b0;
            gap_left = 0;
            drain_hold = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                beats_accepted++;
                if (filter_sample(in_ch.sample, in_ch.restart, rep)) begin
                    reports_due.push_back(rep);
                    reports_predicted++;
                    // Now and then hold off until every report has come out.
                    if (reports_predicted % 9 == 4) drain_hold = 1'b1;
                end
            end
            if (drain_hold && reports_predicted == reports_received) drain_hold = 1'b0;
            if (!in_ch.valid || in_ch.ready) begin
                if (drain_hold) begin
                    in_ch.valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (sample_backlog.size() > 0) begin
                    beat = sample_backlog.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.sample  <= beat.sample;
                    in_ch.restart <= beat.restart;
                    gap_left = pace_mode ? draw_gap() : 0;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Report monitor: stalls at random and checks each beat against the oldest prediction.
    always @(posedge i_clk) begin : report_monitor
        level_report_t want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                reports_received <= reports_received + 1;
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected report: expected none, actual value %0d level %0d",
                             $time, out_ch.reported_value, out_ch.reported_level);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    if (out_ch.reported_value !== want.value) begin
                        $display("%0t: reported_value mismatch: expected %0d, actual %0d",
                                 $time, want.value, out_ch.reported_value);
                        mismatches++;
                    end
                    if (out_ch.reported_level !== want.level) begin
                        $display("%0t: reported_level mismatch: expected %0d, actual %0d",
                                 $time, want.level, out_ch.reported_level);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (pace_mode && $urandom_range(0, 99) < 20) stall_left = draw_gap();
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d reports outstanding",
                     $time, reports_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [SAMPLE_W-1:0] th [4];
        logic [SAMPLE_W-1:0] swap;
        logic [HOLD_W-1:0]   rise;
        logic [HOLD_W-1:0]   fall;
        int                  mode;

        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.restart = 1'b0;
        out_ch.ready = 1'b0;

        // Predictor starts from the reset state.
        for (int k = 0; k < RING_DEPTH; k++) ring_copy[k] = '0;
        ring_wr = 0;
        cand_level = LEVEL_0;
        held_level = LEVEL_0;
        hold_cnt = '0;
        first_pending = 1'b0;
        th_lvl[0] = THRESHOLD_LEVEL0_RST;
        th_lvl[1] = THRESHOLD_LEVEL1_RST;
        th_lvl[2] = THRESHOLD_LEVEL2_RST;
        th_lvl[3] = THRESHOLD_LEVEL3_RST;
        rise_hold = RISE_HOLD_COUNT_RST;
        fall_hold = FALL_HOLD_COUNT_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset register values.
        // Restart at full scale, then hold it until the first report.
        push_beat(65535, 1'b1);
        repeat (6) push_beat(65535, 1'b0);
        // A single low sample is trimmed away.
        push_beat(0, 1'b0);
        // Restart at zero: a lower level still uses the rise count while the first
        // report is pending.
        push_beat(0, 1'b1);
        repeat (6) push_beat(0, 1'b0);
        // Restarts on both sides of every default threshold.
        push_beat(15, 1'b1);
        push_beat(16, 1'b1);
        push_beat(163, 1'b1);
        push_beat(164, 1'b1);
        push_beat(1650, 1'b1);
        push_beat(1651, 1'b1);
        push_beat(15700, 1'b1);
        push_beat(15701, 1'b1);
        // Alternating bit patterns.
        push_beat(16'hAAAA, 1'b0);
        push_beat(16'h5555, 1'b0);
        wait_idle();

        // Extremes: all thresholds at zero with zero hold counts.
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 5'd0, 5'd0);
        fill_random(120);
        wait_idle();

        // Extremes: all thresholds at full scale with hold counts of 30.
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd30, 5'd30);
        fill_random(120);
        wait_idle();

        // Build a running count, then lower the hold below it so the counter wraps.
        set_config(THRESHOLD_LEVEL0_RST, THRESHOLD_LEVEL1_RST, THRESHOLD_LEVEL2_RST,
                   THRESHOLD_LEVEL3_RST, 5'd30, 5'd30);
        add_run(12, 500, 0, 1'b1);
        wait_idle();
        set_config(THRESHOLD_LEVEL0_RST, THRESHOLD_LEVEL1_RST, THRESHOLD_LEVEL2_RST,
                   THRESHOLD_LEVEL3_RST, 5'd3, 5'd30);
        add_run(30, 500, 0, 1'b0);
        random_items += 42;
        wait_idle();

        // Random settings, each followed by a batch of runs and noise.
        while (random_items < RANDOM_ITEMS && phase_count < 60) begin
            mode = $urandom_range(0, 5);
            for (int k = 0; k < 4; k++) begin
                th[k] = SAMPLE_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            end
            rise = HOLD_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 6)
                                                       : $urandom_range(0, 30));
            fall = HOLD_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 12)
                                                       : $urandom_range(0, 30));
            if (mode == 0) begin
                th = '{THRESHOLD_LEVEL0_RST, THRESHOLD_LEVEL1_RST, THRESHOLD_LEVEL2_RST,
                       THRESHOLD_LEVEL3_RST};
            end else if (mode != 4) begin
                // Ascending thresholds; mode 4 keeps them in random order.
                for (int a = 0; a < 3; a++) begin
                    for (int b = 0; b < 3 - a; b++) begin
                        if (th[b] > th[b + 1]) begin
                            swap = th[b];
                            th[b] = th[b + 1];
                            th[b + 1] = swap;
                        end
                    end
                end
            end
            if (mode == 5) begin
                rise = $urandom_range(0, 1) ? 5'd30 : 5'd0;
                fall = $urandom_range(0, 1) ? 5'd30 : 5'd0;
            end
            set_config(th[0], th[1], th[2], th[3], rise, fall);
            pace_mode = ($urandom_range(0, 3) != 0);
            fill_random(150);
            wait_idle();
        end

        if (reports_due.size() != 0) begin
            $display("%0t: %0d expected reports never arrived", $time, reports_due.size());
            mismatches++;
        end
        $display("Covered %0d samples and %0d checked reports across %0d register settings.",
                 beats_accepted, reports_received, phase_count);
        $display("Settings ranged from zero to full-scale thresholds and hold counts 0 to 30.");
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
